### sv/sqsw_pkg.sv
// shared types, constants and the duty table of the swept square channel
package sqsw_pkg;

    localparam int OP_W       = 2;
    localparam int CLK_W      = 12;
    localparam int LEN_LD_W   = 6;
    localparam int DUTY_W     = 2;
    localparam int ENVSET_W   = 8;
    localparam int SWPSET_W   = 7;
    localparam int PER_W      = 11;
    localparam int DIV_W      = 13;
    localparam int SWP_W      = 18;
    localparam int ENV_W      = 19;
    localparam int VOL_W      = 4;
    localparam int PHASES     = 16;
    localparam int PHASE_W    = $clog2(PHASES);
    localparam int SAMPLE_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int LEN_SHIFT      = 14;
    localparam int ENV_STEP_SHIFT = 16;
    localparam int SWP_TIME_SHIFT = 15;

    localparam logic [PER_W:0]   PERIOD_SPAN   = 12'h800;
    localparam logic [DIV_W-1:0] DIVIDER_RESET = 13'h1000;
    localparam logic [VOL_W-1:0] VOLUME_MAX    = 4'hf;

    localparam logic [CFG_IDX_W-1:0] REG_DUTY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_EN   = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_ADVANCE  = 2'd0,
        OP_TRIGGER  = 2'd1,
        OP_LOAD_LEN = 2'd2
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LEN_SUB,
        ST_LEN_WRAP,
        ST_ENV_SUB,
        ST_ENV_WRAP,
        ST_ENV_CHECK,
        ST_SWP_SUB,
        ST_SWP_PREV,
        ST_DIV_CMP,
        ST_DIV_PER,
        ST_DIV_REM,
        ST_DIV_STEP,
        ST_DIV_LOAD,
        ST_SWP_APPLY,
        ST_SWP_RELOAD,
        ST_SWP_REST,
        ST_WRAP,
        ST_TRIG,
        ST_TRIG_DIV,
        ST_LOAD_LEN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty_select;
        logic [ENVSET_W-1:0] envelope_setting;
        logic [SWPSET_W-1:0] sweep_setting;
        logic [PER_W-1:0]    period_value;
        logic                length_enable;
    } cfg_t;

    typedef struct packed {
        op_t                 op;
        logic [CLK_W-1:0]    clock_count;
        logic [LEN_LD_W-1:0] length_load;
    } item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                running;
    } result_t;

    // waveform bit for one of the eight duty positions
    function automatic logic duty_bit(input logic [DUTY_W-1:0] sel, input logic [2:0] idx);
        logic bit_out;
        case (sel)
            2'd0:    bit_out = (idx == 3'd0);
            2'd1:    bit_out = (idx < 3'd2);
            2'd2:    bit_out = (idx < 3'd4);
            default: bit_out = (idx < 3'd6);
        endcase
        return bit_out;
    endfunction

endpackage

### sv/sqsw_alu.sv
// shared add/subtract unit used by the arithmetic steps of the sequencer
module sqsw_alu #(
    parameter int W = 19
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] y,
    output logic         carry
);

    logic [W-1:0] b_eff;

    assign b_eff = sub ? ~b : b;
    // on subtract, carry high means no borrow (a >= b)
    assign {carry, y} = {1'b0, a} + {1'b0, b_eff} + (W + 1)'(sub);

endmodule

### sv/sqsw_core.sv
// sequencer and channel state: counters, sweep, divider division and sample
module sqsw_core
    import sqsw_pkg::*;
#(
    parameter int LENGTH_MAX = 63
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    start,
    input  item_t   item,
    input  cfg_t    cfg,
    output logic    idle,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t result
);

    localparam int LEN_TOP_V = LENGTH_MAX + 1;
    localparam int LW = $clog2(LEN_TOP_V * (1 << LEN_SHIFT) + 1);
    localparam int AW = (LW > ENV_W) ? LW : ENV_W;
    localparam logic [LW-1:0] LEN_RELOAD = LW'(LEN_TOP_V * (1 << LEN_SHIFT));
    localparam logic [AW-1:0] LEN_TOP = AW'(LEN_TOP_V);

    state_t state_reg, state_next;

    // channel state
    logic [DIV_W-1:0]   divider_count_reg, divider_count_next;
    logic [PER_W-1:0]   current_period_reg, current_period_next;
    logic [SWP_W-1:0]   sweep_count_reg, sweep_count_next;
    logic [ENV_W-1:0]   envelope_count_reg, envelope_count_next;
    logic [VOL_W-1:0]   volume_reg, volume_next;
    logic [LW-1:0]      length_count_reg, length_count_next;
    logic [PHASE_W-1:0] wave_phase_reg, wave_phase_next;
    logic               is_running_reg, is_running_next;
    logic               env_up_reg, env_up_next;
    logic [2:0]         env_step_reg, env_step_next;
    logic [2:0]         sw_shift_reg, sw_shift_next;
    logic               sw_sub_reg, sw_sub_next;
    logic [2:0]         sw_time_reg, sw_time_next;

    // working registers of one request
    item_t               item_reg, item_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [CLK_W-1:0]    m_reg, m_next;
    logic [AW-1:0]       tmp_reg, tmp_next;
    logic                sweep_due_reg, sweep_due_next;
    logic [DIV_W-1:0]    per_reg, per_next;
    logic [CLK_W-1:0]    rem_reg, rem_next;
    logic [CLK_W-1:0]    dvd_reg, dvd_next;
    logic [PHASE_W-1:0]  quo_reg, quo_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [PHASE_W-1:0]  steps_reg, steps_next;

    logic [AW-1:0] alu_a, alu_b, alu_y;
    logic          alu_sub, alu_c, alu_gt;

    logic [DIV_W-1:0]   trial;
    logic [PER_W-1:0]   delta;
    logic [ENV_W-1:0]   env_reload;
    logic [SWP_W-1:0]   sweep_reload;
    logic [PHASE_W-1:0] phase_sum;
    logic               no_clocks;
    state_t             div_exit;

    sqsw_alu #(.W(AW)) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .y     (alu_y),
        .carry (alu_c)
    );

    assign alu_gt       = alu_c && (alu_y != '0);
    assign trial        = {rem_reg, dvd_reg[CLK_W-1]};
    assign delta        = current_period_reg >> sw_shift_reg;
    assign env_reload   = {env_step_reg, {ENV_STEP_SHIFT{1'b0}}};
    assign sweep_reload = {sw_time_reg, {SWP_TIME_SHIFT{1'b0}}};
    assign phase_sum    = wave_phase_reg + steps_reg;
    assign no_clocks    = (item_reg.clock_count == '0);
    assign div_exit     = sweep_due_reg ? ST_SWP_APPLY : ST_WRAP;

    // operand selection for the shared unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            ST_LEN_SUB: begin
                alu_a = AW'(length_count_reg);
                alu_b = AW'(item_reg.clock_count);
            end
            ST_LEN_WRAP: begin
                alu_a   = AW'(LEN_RELOAD);
                alu_b   = tmp_reg;
                alu_sub = 1'b0;
            end
            ST_ENV_SUB: begin
                alu_a = AW'(envelope_count_reg);
                alu_b = AW'(item_reg.clock_count);
            end
            ST_ENV_WRAP: begin
                alu_a   = AW'(env_reload);
                alu_b   = tmp_reg;
                alu_sub = 1'b0;
            end
            ST_SWP_SUB: begin
                alu_a = AW'(sweep_count_reg);
                alu_b = AW'(item_reg.clock_count);
            end
            ST_SWP_PREV: begin
                alu_a = AW'(sweep_count_reg);
                alu_b = AW'(1'b1);
            end
            ST_DIV_CMP: begin
                alu_a = AW'(divider_count_reg);
                alu_b = AW'(m_reg);
            end
            ST_DIV_PER, ST_TRIG_DIV: begin
                alu_a = AW'(PERIOD_SPAN);
                alu_b = AW'(current_period_reg);
            end
            ST_DIV_REM: begin
                alu_a = AW'(m_reg);
                alu_b = AW'(divider_count_reg);
            end
            ST_DIV_STEP: begin
                alu_a = AW'(trial);
                alu_b = AW'(per_reg);
            end
            ST_DIV_LOAD: begin
                alu_a = AW'(per_reg);
                alu_b = AW'(rem_reg);
            end
            ST_SWP_APPLY: begin
                alu_a   = AW'(current_period_reg);
                alu_b   = AW'(delta);
                alu_sub = sw_sub_reg;
            end
            ST_SWP_RELOAD: begin
                alu_a   = AW'(sweep_reload);
                alu_b   = tmp_reg;
                alu_sub = 1'b0;
            end
            ST_SWP_REST: begin
                alu_a = AW'(item_reg.clock_count);
                alu_b = AW'(m_reg);
            end
            ST_LOAD_LEN: begin
                alu_a = LEN_TOP;
                alu_b = AW'(item_reg.length_load);
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    case (item.op)
                        OP_ADVANCE:  state_next = ST_LEN_SUB;
                        OP_TRIGGER:  state_next = ST_TRIG;
                        OP_LOAD_LEN: state_next = ST_LOAD_LEN;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_LEN_SUB: begin
                if (!cfg.length_enable || no_clocks || alu_gt) begin
                    state_next = ST_ENV_SUB;
                end else begin
                    state_next = ST_LEN_WRAP;
                end
            end
            ST_LEN_WRAP: state_next = ST_ENV_SUB;
            ST_ENV_SUB: begin
                if (!is_running_reg) begin
                    state_next = ST_FINISH;
                end else if (env_step_reg == '0 || no_clocks || alu_gt) begin
                    state_next = ST_ENV_CHECK;
                end else begin
                    state_next = ST_ENV_WRAP;
                end
            end
            ST_ENV_WRAP: state_next = ST_ENV_CHECK;
            ST_ENV_CHECK: begin
                if (volume_reg == '0 && !env_up_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SWP_SUB;
                end
            end
            ST_SWP_SUB: begin
                if (sw_time_reg == '0 || alu_gt) begin
                    state_next = ST_DIV_CMP;
                end else begin
                    state_next = ST_SWP_PREV;
                end
            end
            ST_SWP_PREV: state_next = ST_DIV_CMP;
            ST_DIV_CMP: begin
                if (m_reg == '0 || alu_gt) begin
                    state_next = div_exit;
                end else begin
                    state_next = ST_DIV_PER;
                end
            end
            ST_DIV_PER: state_next = ST_DIV_REM;
            ST_DIV_REM: state_next = ST_DIV_STEP;
            ST_DIV_STEP: begin
                if (cnt_reg == 4'(CLK_W - 1)) begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: state_next = div_exit;
            ST_SWP_APPLY: begin
                // period past the 11-bit range silences the channel
                if (!sw_sub_reg && alu_y[PER_W]) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SWP_RELOAD;
                end
            end
            ST_SWP_RELOAD: state_next = ST_SWP_REST;
            ST_SWP_REST:   state_next = ST_DIV_CMP;
            ST_WRAP:       state_next = ST_FINISH;
            ST_TRIG:       state_next = ST_TRIG_DIV;
            ST_TRIG_DIV:   state_next = ST_FINISH;
            ST_LOAD_LEN:   state_next = ST_FINISH;
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        divider_count_next  = divider_count_reg;
        current_period_next = current_period_reg;
        sweep_count_next    = sweep_count_reg;
        envelope_count_next = envelope_count_reg;
        volume_next         = volume_reg;
        length_count_next   = length_count_reg;
        wave_phase_next     = wave_phase_reg;
        is_running_next     = is_running_reg;
        env_up_next         = env_up_reg;
        env_step_next       = env_step_reg;
        sw_shift_next       = sw_shift_reg;
        sw_sub_next         = sw_sub_reg;
        sw_time_next        = sw_time_reg;
        item_next           = item_reg;
        sample_next         = sample_reg;
        m_next              = m_reg;
        tmp_next            = tmp_reg;
        sweep_due_next      = sweep_due_reg;
        per_next            = per_reg;
        rem_next            = rem_reg;
        dvd_next            = dvd_reg;
        quo_next            = quo_reg;
        cnt_next            = cnt_reg;
        steps_next          = steps_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    item_next   = item;
                    sample_next = '0;
                end
            end
            ST_LEN_SUB: begin
                if (cfg.length_enable && !no_clocks) begin
                    if (alu_gt) begin
                        length_count_next = alu_y[LW-1:0];
                    end else begin
                        tmp_next        = alu_y;
                        is_running_next = 1'b0;
                    end
                end
            end
            ST_LEN_WRAP: length_count_next = alu_y[LW-1:0];
            ST_ENV_SUB: begin
                if (is_running_reg && env_step_reg != '0 && !no_clocks) begin
                    if (alu_gt) begin
                        envelope_count_next = alu_y[ENV_W-1:0];
                    end else begin
                        tmp_next = alu_y;
                        if (env_up_reg) begin
                            if (volume_reg != VOLUME_MAX) begin
                                volume_next = volume_reg + 1'b1;
                            end
                        end else if (volume_reg != '0) begin
                            volume_next = volume_reg - 1'b1;
                        end
                    end
                end
            end
            ST_ENV_WRAP: envelope_count_next = alu_y[ENV_W-1:0];
            ST_ENV_CHECK: begin
                if (volume_reg == '0 && !env_up_reg) begin
                    is_running_next = 1'b0;
                end
            end
            ST_SWP_SUB: begin
                steps_next = '0;
                if (sw_time_reg == '0) begin
                    m_next         = item_reg.clock_count;
                    sweep_due_next = 1'b0;
                end else if (alu_gt) begin
                    sweep_count_next = alu_y[SWP_W-1:0];
                    m_next           = item_reg.clock_count;
                    sweep_due_next   = 1'b0;
                end else begin
                    // sweep fires inside this advance: run the divider up to it first
                    tmp_next       = alu_y;
                    sweep_due_next = 1'b1;
                end
            end
            ST_SWP_PREV: m_next = alu_y[CLK_W-1:0];
            ST_DIV_CMP: begin
                if (m_reg != '0 && alu_gt) begin
                    divider_count_next = alu_y[DIV_W-1:0];
                end
            end
            ST_DIV_PER: per_next = {alu_y[PER_W:0], 1'b0};
            ST_DIV_REM: begin
                dvd_next = alu_y[CLK_W-1:0];
                rem_next = '0;
                quo_next = '0;
                cnt_next = '0;
            end
            ST_DIV_STEP: begin
                // one restoring division bit per cycle
                if (alu_c) begin
                    rem_next = alu_y[CLK_W-1:0];
                end else begin
                    rem_next = trial[CLK_W-1:0];
                end
                quo_next = {quo_reg[PHASE_W-2:0], alu_c};
                dvd_next = {dvd_reg[CLK_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
            end
            ST_DIV_LOAD: begin
                divider_count_next = alu_y[DIV_W-1:0];
                steps_next         = steps_reg + quo_reg + 1'b1;
            end
            ST_SWP_APPLY: begin
                if (sw_sub_reg) begin
                    if (sw_shift_reg != '0) begin
                        current_period_next = alu_y[PER_W-1:0];
                    end
                end else if (alu_y[PER_W]) begin
                    is_running_next = 1'b0;
                end else begin
                    current_period_next = alu_y[PER_W-1:0];
                end
            end
            ST_SWP_RELOAD: sweep_count_next = alu_y[SWP_W-1:0];
            ST_SWP_REST: begin
                m_next         = alu_y[CLK_W-1:0];
                sweep_due_next = 1'b0;
            end
            ST_WRAP: begin
                wave_phase_next = phase_sum;
                sample_next     = duty_bit(cfg.duty_select, phase_sum[PHASE_W-1:1])
                                  ? volume_reg : '0;
            end
            ST_TRIG: begin
                wave_phase_next     = '0;
                current_period_next = cfg.period_value;
                sw_shift_next       = cfg.sweep_setting[2:0];
                sw_sub_next         = cfg.sweep_setting[3];
                sw_time_next        = cfg.sweep_setting[6:4];
                sweep_count_next    = {cfg.sweep_setting[6:4], {SWP_TIME_SHIFT{1'b0}}};
                volume_next         = cfg.envelope_setting[7:4];
                env_up_next         = cfg.envelope_setting[3];
                env_step_next       = cfg.envelope_setting[2:0];
                envelope_count_next = {cfg.envelope_setting[2:0], {ENV_STEP_SHIFT{1'b0}}};
                is_running_next     = (cfg.envelope_setting[7:4] != '0)
                                      || cfg.envelope_setting[3];
            end
            ST_TRIG_DIV: divider_count_next = {alu_y[PER_W:0], 1'b0};
            ST_LOAD_LEN: begin
                // a load beyond the top gives an empty count
                if (alu_c) begin
                    length_count_next = {alu_y[LW-LEN_SHIFT-1:0], {LEN_SHIFT{1'b0}}};
                end else begin
                    length_count_next = '0;
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            divider_count_reg  <= DIVIDER_RESET;
            current_period_reg <= '0;
            sweep_count_reg    <= '0;
            envelope_count_reg <= '0;
            volume_reg         <= '0;
            length_count_reg   <= '0;
            wave_phase_reg     <= '0;
            is_running_reg     <= 1'b0;
            env_up_reg         <= 1'b0;
            env_step_reg       <= '0;
            sw_shift_reg       <= '0;
            sw_sub_reg         <= 1'b0;
            sw_time_reg        <= '0;
            sweep_due_reg      <= 1'b0;
            cnt_reg            <= '0;
            sample_reg         <= '0;
        end else begin
            state_reg          <= state_next;
            divider_count_reg  <= divider_count_next;
            current_period_reg <= current_period_next;
            sweep_count_reg    <= sweep_count_next;
            envelope_count_reg <= envelope_count_next;
            volume_reg         <= volume_next;
            length_count_reg   <= length_count_next;
            wave_phase_reg     <= wave_phase_next;
            is_running_reg     <= is_running_next;
            env_up_reg         <= env_up_next;
            env_step_reg       <= env_step_next;
            sw_shift_reg       <= sw_shift_next;
            sw_sub_reg         <= sw_sub_next;
            sw_time_reg        <= sw_time_next;
            sweep_due_reg      <= sweep_due_next;
            cnt_reg            <= cnt_next;
            sample_reg         <= sample_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        m_reg     <= m_next;
        tmp_reg   <= tmp_next;
        per_reg   <= per_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        steps_reg <= steps_next;
    end

    assign idle           = (state_reg == ST_IDLE);
    assign res_valid      = (state_reg == ST_FINISH);
    assign result.sample  = sample_reg;
    assign result.running = is_running_reg;

endmodule

### sv/square_channel_with_sweep.sv
// top level of the swept square channel: stream ports, config registers, result register
//
// usage: each request on the s_ channel is one op in s_tuser (0 advance by
// clock_count clocks, 1 trigger, 2 load length, 3 no-op) and gives exactly one
// result on the m_ channel: the sample (duty bit times volume) and the running flag.
// configuration registers are written over the cfg_ channel (index 0 duty,
// 1 envelope, 2 sweep, 3 period, 4 length enable); the user must write them only
// while no request is in flight, which the block itself does not enforce. a request
// is worked on by a sequencer around one shared add/subtract unit; s_tready is
// high only while the sequencer is idle, one request at a time. a trigger loads
// the channel state and then the divider reload, a load length sets the length
// count, and a no-op goes straight to its result. an advance steps the length,
// envelope and sweep counts and then the divider; a divider expiry run uses the
// 12-step bit-serial division, and an advance that hits a sweep step can run the
// divider twice. the next request can be taken in the cycle after the result
// leaves the sequencer. the result sits in an output register; while the receiver
// stalls the next request is still taken and worked on, and only its hand-off waits.
// reset (aresetn low, synchronous) clears the channel state, the config
// registers and the result register; no clearing pass is needed.
module square_channel_with_sweep
    import sqsw_pkg::*;
#(
    parameter int LENGTH_MAX = 63
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // clock_count[11:0], length_load[17:12], zero pad
    input  logic [OP_W-1:0]       s_tuser,   // op[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // sample[3:0], running[4], zero pad
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    item_t   item;
    result_t core_res;
    logic    core_idle, core_valid, core_ready, start;
    logic    m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = core_idle;
    assign start     = s_tvalid && core_idle;

    assign item.op          = op_t'(s_tuser);
    assign item.clock_count = s_tdata[CLK_W-1:0];
    assign item.length_load = s_tdata[CLK_W+LEN_LD_W-1:CLK_W];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_DUTY:     cfg_next.duty_select      = cfg_data[DUTY_W-1:0];
                REG_ENVELOPE: cfg_next.envelope_setting = cfg_data[ENVSET_W-1:0];
                REG_SWEEP:    cfg_next.sweep_setting    = cfg_data[SWPSET_W-1:0];
                REG_PERIOD:   cfg_next.period_value     = cfg_data[PER_W-1:0];
                REG_LEN_EN:   cfg_next.length_enable    = cfg_data[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    sqsw_core #(.LENGTH_MAX(LENGTH_MAX)) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .item      (item),
        .cfg       (cfg_reg),
        .idle      (core_idle),
        .res_valid (core_valid),
        .res_ready (core_ready),
        .result    (core_res)
    );

    // result register frees up when empty or being taken
    assign core_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (core_ready) begin
            m_tvalid_next = core_valid;
            if (core_valid) begin
                m_tdata_next = {3'b000, core_res.running, core_res.sample};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end else begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### dv/tb_square_channel_with_sweep.sv
// self-checking testbench for the swept square channel: stream stimulus, predictor, result check
module tb_square_channel_with_sweep;
    timeunit 1ns;
    timeprecision 1ps;

    import sqsw_pkg::*;

    localparam int LEN_MAX        = 63;
    localparam int LEN_TOP        = LEN_MAX + 1;
    localparam int LEN_CNT_W      = 21;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;

    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    // duty waveforms, bit i is waveform position i, one byte per duty select
    localparam logic [31:0] DUTY_WAVES = {8'b00111111, 8'b00001111, 8'b00000011, 8'b00000001};

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    square_channel_with_sweep #(
        .LENGTH_MAX(LEN_MAX)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // register shadows as the channel sees them
    logic [DUTY_W-1:0]   sh_duty;
    logic [ENVSET_W-1:0] sh_env;
    logic [SWPSET_W-1:0] sh_sweep;
    logic [PER_W-1:0]    sh_period;
    logic                sh_len_en;

    // predicted channel state
    logic [DIV_W-1:0]     div_cnt;
    logic [PER_W-1:0]     cur_period;
    logic [SWP_W-1:0]     swp_cnt;
    logic [ENV_W-1:0]     env_cnt;
    logic [VOL_W-1:0]     vol;
    logic [LEN_CNT_W-1:0] len_cnt;
    logic [PHASE_W-1:0]   phase;
    logic                 run;
    logic                 env_up;
    logic [2:0]           env_step;
    logic [2:0]           sw_shift;
    logic                 sw_sub;
    logic [2:0]           sw_time;

    result_t tone_q[$];
    int      errors;
    bit      send_calm;
    bit      recv_calm;

    always #10 aclk = ~aclk;

    function automatic int unsigned div_reload();
        return 2 * (int'(PERIOD_SPAN) - int'(cur_period));
    endfunction

    // runs the period divider, returns the number of expiries
    function automatic int unsigned div_expiries(int unsigned n);
        int unsigned p, k, dc;
        dc = div_cnt;
        if (n == 0) return 0;
        if (dc > n) begin
            div_cnt = DIV_W'(dc - n);
            return 0;
        end
        n -= dc;
        p = div_reload();
        k = 1 + n / p;
        div_cnt = DIV_W'(p - (n % p));
        return k;
    endfunction

    function automatic bit length_hit(int unsigned n);
        bit          hit;
        int unsigned lc;
        hit = 0;
        lc = len_cnt;
        if (!sh_len_en) return 0;
        while (n != 0) begin
            if (lc > n) begin
                lc -= n;
                n = 0;
            end else begin
                hit = 1;
                n -= lc;
                lc = LEN_TOP << LEN_SHIFT;
            end
        end
        len_cnt = LEN_CNT_W'(lc);
        return hit;
    endfunction

    function automatic bit envelope_silent(int unsigned n);
        int unsigned ec;
        ec = env_cnt;
        if (env_step != 0) begin
            while (n != 0) begin
                if (ec > n) begin
                    ec -= n;
                    n = 0;
                end else begin
                    n -= ec;
                    if (env_up) begin
                        if (vol != VOLUME_MAX) vol++;
                    end else if (vol != 0) begin
                        vol--;
                    end
                    ec = env_step * 32'h10000;
                end
            end
        end
        env_cnt = ENV_W'(ec);
        return (vol == 0 && !env_up);
    endfunction

    // sweep and divider together; stop flags a period overflow
    function automatic int unsigned sweep_expiries(int unsigned n, output bit stop);
        int unsigned cnt, r, sc, delta, sum;
        cnt = 0;
        stop = 0;
        if (sw_time == 0) return div_expiries(n);
        sc = swp_cnt;
        while (n != 0) begin
            r = n;
            if (sc < r) r = sc;
            if (div_cnt < r) r = div_cnt;
            sc -= r;
            if (sc == 0) begin
                delta = cur_period >> sw_shift;
                if (sw_sub) begin
                    if (sw_shift != 0 && delta <= cur_period)
                        cur_period = PER_W'(cur_period - delta);
                end else begin
                    sum = cur_period + delta;
                    if (sum > 32'h7ff) begin
                        stop = 1;
                        break;
                    end
                    cur_period = PER_W'(sum);
                end
                sc = sw_time * 32'h8000;
            end
            cnt += div_expiries(r);
            n -= r;
        end
        swp_cnt = SWP_W'(sc);
        return cnt;
    endfunction

    function automatic result_t predict_tone(logic [OP_W-1:0] op, logic [CLK_W-1:0] clocks,
                                             logic [LEN_LD_W-1:0] t1);
        result_t     res;
        int unsigned steps, t;
        bit          stop;
        res.sample = '0;
        case (op)
            OP_ADVANCE: begin
                if (length_hit(clocks)) run = 0;
                if (run) begin
                    if (envelope_silent(clocks)) run = 0;
                end
                if (run) begin
                    steps = sweep_expiries(clocks, stop);
                    if (stop) begin
                        run = 0;
                    end else begin
                        phase = phase + steps[3:0];
                        res.sample = DUTY_WAVES[{sh_duty, phase[3:1]}] ? vol : '0;
                    end
                end
            end
            OP_TRIGGER: begin
                phase = '0;
                cur_period = sh_period;
                div_cnt = DIV_W'(div_reload());
                sw_shift = sh_sweep[2:0];
                sw_sub = sh_sweep[3];
                sw_time = sh_sweep[6:4];
                swp_cnt = SWP_W'(sw_time * 32'h8000);
                vol = sh_env[7:4];
                env_up = sh_env[3];
                env_step = sh_env[2:0];
                env_cnt = ENV_W'(env_step * 32'h10000);
                run = (vol != 0 || env_up);
            end
            OP_LOAD_LEN: begin
                t = t1;
                if (t > LEN_TOP) t = LEN_TOP;
                len_cnt = LEN_CNT_W'((LEN_TOP - t) << LEN_SHIFT);
            end
            default: ;
        endcase
        res.running = run;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (send_calm) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_stall();
        int r;
        if (recv_calm) return 0;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [CLK_W-1:0] rand_clocks();
        int r;
        r = $urandom_range(99);
        if (r < 45) return CLK_W'($urandom);
        if (r < 65) return 12'hfff;
        if (r < 80) return CLK_W'($urandom_range(0, 7));
        return CLK_W'($urandom) | 12'h800;
    endfunction

    task automatic send_op(logic [OP_W-1:0] op, logic [CLK_W-1:0] clocks,
                           logic [LEN_LD_W-1:0] t1);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, t1, clocks};
        do @(posedge aclk); while (!s_tready);
        tone_q.push_back(predict_tone(op, clocks, t1));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_DUTY:     sh_duty   = val[DUTY_W-1:0];
            REG_ENVELOPE: sh_env    = val[ENVSET_W-1:0];
            REG_SWEEP:    sh_sweep  = val[SWPSET_W-1:0];
            REG_PERIOD:   sh_period = val[PER_W-1:0];
            REG_LEN_EN:   sh_len_en = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until every request has been answered
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tone_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        // out of reset nothing runs and the length count is zero
        send_op(OP_ADVANCE, 12'd0, 6'd0);
        send_op(OP_NOP, 12'hfff, 6'h3f);
        send_op(OP_ADVANCE, 12'hfff, 6'd0);
        wait_idle();
        write_reg(REG_LEN_EN, 11'd1);
        write_reg(REG_ENVELOPE, 11'h0f0);
        write_reg(REG_PERIOD, 11'h7ff);
        write_reg(REG_DUTY, 11'd2);
        write_reg(REG_SWEEP, 11'd0);
        send_op(OP_TRIGGER, 12'd0, 6'd0);
        send_op(OP_ADVANCE, 12'd0, 6'd0);
        // zero length count expires on the first nonzero advance
        send_op(OP_ADVANCE, 12'd1, 6'd0);
        wait_idle();
        write_reg(REG_LEN_EN, 11'd0);
        send_op(OP_TRIGGER, 12'hfff, 6'h3f);
        send_op(OP_ADVANCE, 12'd1, 6'd0);
        send_op(OP_ADVANCE, 12'hfff, 6'd0);
        send_op(OP_ADVANCE, 12'd3, 6'd0);
        send_op(OP_LOAD_LEN, 12'd0, 6'd0);
        send_op(OP_LOAD_LEN, 12'd0, 6'h3f);
        // silent start: volume 0 decreasing never runs, volume 0 increasing does
        wait_idle();
        write_reg(REG_ENVELOPE, 11'h000);
        send_op(OP_TRIGGER, 12'd0, 6'd0);
        send_op(OP_ADVANCE, 12'd5, 6'd0);
        wait_idle();
        write_reg(REG_ENVELOPE, 11'h008);
        send_op(OP_TRIGGER, 12'd0, 6'd0);
        send_op(OP_ADVANCE, 12'd7, 6'd0);
        // added sweep past the top period silences the channel
        wait_idle();
        write_reg(REG_SWEEP, 11'h010);
        write_reg(REG_PERIOD, 11'h400);
        write_reg(REG_ENVELOPE, 11'h0f7);
        send_op(OP_TRIGGER, 12'd0, 6'd0);
        repeat (9) send_op(OP_ADVANCE, 12'hfff, 6'd0);
    endtask

    task automatic test_duty_walk();
        for (int d = 0; d < 4; d++) begin
            wait_idle();
            write_reg(REG_DUTY, CFG_DATA_W'(d));
            write_reg(REG_ENVELOPE, 11'h0f0);
            write_reg(REG_PERIOD, 11'h7ff);
            write_reg(REG_SWEEP, 11'd0);
            send_op(OP_TRIGGER, 12'd0, 6'd0);
            repeat (12) send_op(OP_ADVANCE, CLK_W'($urandom_range(0, 5)), 6'd0);
        end
    endtask

    task automatic test_envelope();
        wait_idle();
        write_reg(REG_PERIOD, CFG_DATA_W'($urandom));
        write_reg(REG_ENVELOPE, 11'h021);
        send_op(OP_TRIGGER, 12'd0, 6'd0);
        repeat (40) send_op(OP_ADVANCE, 12'hfff, 6'd0);
        wait_idle();
        write_reg(REG_ENVELOPE, 11'h0d9);
        send_op(OP_TRIGGER, 12'd0, 6'd0);
        repeat (40) send_op(OP_ADVANCE, 12'hfff, 6'd0);
    endtask

    task automatic test_sweep();
        logic [SWPSET_W-1:0] sweeps [5];
        logic [PER_W-1:0]    periods [5];
        int                  counts [5];
        sweeps  = '{7'h18, 7'h19, 7'h17, 7'h21, 7'h7b};
        periods = '{11'h3ff, 11'h7f0, 11'h000, 11'h500, 11'h6aa};
        counts  = '{20, 20, 20, 36, 20};
        for (int i = 0; i < 5; i++) begin
            wait_idle();
            write_reg(REG_SWEEP, CFG_DATA_W'(sweeps[i]));
            write_reg(REG_PERIOD, CFG_DATA_W'(periods[i]));
            write_reg(REG_ENVELOPE, 11'h0f0);
            send_op(OP_TRIGGER, 12'd0, 6'd0);
            repeat (counts[i]) send_op(OP_ADVANCE, rand_clocks() | 12'hf00, 6'd0);
        end
    endtask

    task automatic test_length();
        wait_idle();
        write_reg(REG_SWEEP, 11'd0);
        write_reg(REG_LEN_EN, 11'd1);
        send_op(OP_LOAD_LEN, 12'd0, 6'h3f);
        send_op(OP_TRIGGER, 12'd0, 6'd0);
        repeat (6) send_op(OP_ADVANCE, 12'hfff, 6'd0);
        // length keeps counting while stopped
        send_op(OP_LOAD_LEN, 12'd0, 6'd60);
        repeat (6) send_op(OP_ADVANCE, 12'hfff, 6'd0);
        send_op(OP_TRIGGER, 12'd0, 6'd0);
        send_op(OP_LOAD_LEN, 12'd0, 6'd62);
        repeat (10) send_op(OP_ADVANCE, 12'hfff, 6'd0);
        wait_idle();
        write_reg(REG_LEN_EN, 11'd0);
    endtask

    task automatic test_random();
        int n_items, r;
        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            send_calm = ($urandom_range(3) == 0);
            recv_calm = ($urandom_range(3) == 0);
            if (ph == 0) begin
                write_reg(REG_DUTY, 11'd3);
                write_reg(REG_ENVELOPE, 11'h0ff);
                write_reg(REG_SWEEP, 11'h07f);
                write_reg(REG_PERIOD, 11'h7ff);
                write_reg(REG_LEN_EN, 11'd1);
            end else if (ph == 1) begin
                write_reg(REG_DUTY, 11'd0);
                write_reg(REG_ENVELOPE, 11'h000);
                write_reg(REG_SWEEP, 11'h000);
                write_reg(REG_PERIOD, 11'h000);
                write_reg(REG_LEN_EN, 11'd0);
            end else begin
                if ($urandom_range(3) != 0) write_reg(REG_DUTY, CFG_DATA_W'($urandom_range(3)));
                if ($urandom_range(3) != 0) begin
                    case ($urandom_range(5))
                        0, 1:    r = $urandom_range(255);
                        2, 3:    r = int'({4'($urandom_range(1, 4)), 1'($urandom), 3'd1});
                        4:       r = 0;
                        default: r = 255;
                    endcase
                    write_reg(REG_ENVELOPE, CFG_DATA_W'(r));
                end
                if ($urandom_range(3) != 0) begin
                    case ($urandom_range(3))
                        0, 1:    r = $urandom_range(127);
                        2:       r = 0;
                        default: r = 127;
                    endcase
                    write_reg(REG_SWEEP, CFG_DATA_W'(r));
                end
                if ($urandom_range(3) != 0) begin
                    case ($urandom_range(4))
                        0, 1:    r = $urandom_range(2047);
                        2:       r = $urandom_range(11'h700, 11'h7ff);
                        3:       r = 0;
                        default: r = 2047;
                    endcase
                    write_reg(REG_PERIOD, CFG_DATA_W'(r));
                end
                if ($urandom_range(3) != 0) write_reg(REG_LEN_EN, CFG_DATA_W'($urandom_range(1)));
            end
            if ($urandom_range(1)) send_op(OP_LOAD_LEN, rand_clocks(), 6'($urandom_range(32, 63)));
            send_op(OP_TRIGGER, rand_clocks(), 6'($urandom));
            n_items = $urandom_range(40, 60);
            repeat (n_items) begin
                r = $urandom_range(99);
                if (r < 80) begin
                    send_op(OP_ADVANCE, rand_clocks(), 6'($urandom));
                end else if (r < 86) begin
                    send_op(OP_TRIGGER, rand_clocks(), 6'($urandom));
                end else if (r < 92) begin
                    send_op(OP_LOAD_LEN, rand_clocks(), 6'($urandom));
                end else if (r < 97) begin
                    send_op(OP_NOP, rand_clocks(), 6'($urandom));
                end else begin
                    wait_idle();
                    send_op(OP_ADVANCE, rand_clocks(), 6'($urandom));
                end
            end
        end
        send_calm = 0;
        recv_calm = 0;
    endtask

    // receiver with random back-pressure
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = pick_stall();
            end
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tone_q.size() == 0) begin
                $error("result with no request pending: sample %0d running %0d",
                       m_tdata[3:0], m_tdata[4]);
                errors++;
            end else begin
                want = tone_q.pop_front();
                if (want.sample != m_tdata[3:0]) begin
                    $error("sample: expected %0d, actual %0d", want.sample, m_tdata[3:0]);
                    errors++;
                end
                if (want.running != m_tdata[4]) begin
                    $error("running: expected %0d, actual %0d", want.running, m_tdata[4]);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : main
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors    = 0;
        send_calm = 0;
        recv_calm = 0;
        sh_duty   = '0;
        sh_env    = '0;
        sh_sweep  = '0;
        sh_period = '0;
        sh_len_en = 1'b0;
        div_cnt    = DIVIDER_RESET;
        cur_period = '0;
        swp_cnt    = '0;
        env_cnt    = '0;
        vol        = '0;
        len_cnt    = '0;
        phase      = '0;
        run        = 1'b0;
        env_up     = 1'b0;
        env_step   = '0;
        sw_shift   = '0;
        sw_sub     = 1'b0;
        sw_time    = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_duty_walk();
        test_envelope();
        test_sweep();
        test_length();
        test_random();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tone_q.size() != 0) begin
            $error("%0d requests never answered", tone_q.size());
            errors++;
        end
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
sv/sqsw_pkg.sv
sv/sqsw_alu.sv
sv/sqsw_core.sv
sv/square_channel_with_sweep.sv
dv/tb_square_channel_with_sweep.sv
